[rtl/line_pixel_coverage_core_macros.svh]
// Assertion macros for the line pixel coverage core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LINE_PIXEL_COVERAGE_CORE_MACROS_SVH
`define LINE_PIXEL_COVERAGE_CORE_MACROS_SVH

// same-cycle implication
`define LPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_pixel_coverage_core: check failed");

// next-cycle implication
`define LPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_pixel_coverage_core: check failed");

`endif

[rtl/lpc_pkg.sv]
// Shared constants and types for the line pixel coverage core.
// No dependencies.
package lpc_pkg;

   localparam int COORD_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_X   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_Y   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_X     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_Y     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANTIALIAS = 3'd4;

   localparam logic [7:0] LEVEL_FULL = 8'd255;

   typedef enum logic [1:0] {
      SETUP_LOAD,
      SETUP_DIV,
      SETUP_DONE
   } setup_state_type;

endpackage

[rtl/lpc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Uses lpc_pkg for default widths.
module lpc_div import lpc_pkg::*; #(
   parameter int NUM_BITS = COORD_BITS_DEF + FRAC_BITS_DEF,
   parameter int DEN_BITS = COORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                busy,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   assign shifted = {rem_ff, quot_ff[NUM_BITS-1]};
   assign diff    = shifted - {1'b0, den};
   assign fits    = shifted >= {1'b0, den};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quot_in = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
         quot_in = {quot_ff[NUM_BITS-2:0], fits};
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[rtl/line_pixel_coverage_core.sv]
// Line pixel coverage core: top level with line setup and pixel pipeline.
// Depends on lpc_pkg, lpc_div and line_pixel_coverage_core_macros.svh.
//
// Takes one pixel per clock while rsp_ready does not stall the pipeline,
// and returns one result per pixel, in order, through stages 1 to 3 and
// the output register. Endpoints and the antialias switch are set through
// the csr port while no pixels are in flight. Each csr write (and reset)
// starts a line setup that holds req_ready low until the bit-serial slope
// divider is done; then pixels stream at full rate. The slope multiply, the
// intercept add with rounding, and the level scaling each have a stage.
`include "line_pixel_coverage_core_macros.svh"

module line_pixel_coverage_core import lpc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [COORD_BITS-1:0]     req_pixel_x,
   input  logic [COORD_BITS-1:0]     req_pixel_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_write_enable,
   output logic [7:0]                rsp_red_level,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata
);

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int NB  = C + F;
   localparam int KW  = F + 2;
   localparam int PW  = C + F + 3;
   localparam int YW  = C + 3;
   localparam int DW  = C + 4;
   localparam logic [PW-1:0]        HALF_FX  = PW'(1) << (F - 1);
   localparam logic signed [DW-1:0] DIFF_ONE = DW'(1);

   // configuration registers
   logic [C-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic         antialias_ff;
   logic         csr_accept;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         antialias_ff <= 1'b0;
      end else if (csr_accept) begin
         case (csr_index)
            CSR_START_X:   start_x_ff   <= csr_wdata;
            CSR_START_Y:   start_y_ff   <= csr_wdata;
            CSR_END_X:     end_x_ff     <= csr_wdata;
            CSR_END_Y:     end_y_ff     <= csr_wdata;
            CSR_ANTIALIAS: antialias_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // line setup sequencer
   setup_state_type setup_state_ff, setup_state_in;
   logic div_start, div_busy, div_done, setup_ready, k_load;

   always_comb begin
      case (setup_state_ff)
         SETUP_LOAD: setup_state_in = SETUP_DIV;
         SETUP_DIV:  setup_state_in = div_done ? SETUP_DONE : SETUP_DIV;
         SETUP_DONE: setup_state_in = SETUP_DONE;
         default:    setup_state_in = SETUP_LOAD;
      endcase
      if (csr_accept) begin
         setup_state_in = SETUP_LOAD;
      end
   end

   always_comb begin
      div_start   = 1'b0;
      setup_ready = 1'b0;
      k_load      = 1'b0;
      case (setup_state_ff)
         SETUP_LOAD: div_start   = 1'b1;
         SETUP_DIV:  k_load      = div_done;
         SETUP_DONE: setup_ready = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_state_ff <= SETUP_LOAD;
      end else begin
         setup_state_ff <= setup_state_in;
      end
   end

   // line geometry, major axis first
   logic signed [C:0] dx_w, dy_w, ndx_w, ndy_w;
   logic [C-1:0]      adx, ady, amaj, amin, maj_a, maj_b, min_a;
   logic              steep;

   assign dx_w  = $signed({1'b0, end_x_ff}) - $signed({1'b0, start_x_ff});
   assign dy_w  = $signed({1'b0, end_y_ff}) - $signed({1'b0, start_y_ff});
   assign ndx_w = -dx_w;
   assign ndy_w = -dy_w;
   assign adx   = dx_w[C] ? ndx_w[C-1:0] : dx_w[C-1:0];
   assign ady   = dy_w[C] ? ndy_w[C-1:0] : dy_w[C-1:0];
   assign steep = adx < ady;
   assign amaj  = steep ? ady : adx;
   assign amin  = steep ? adx : ady;
   assign maj_a = steep ? start_y_ff : start_x_ff;
   assign maj_b = steep ? end_y_ff : end_x_ff;
   assign min_a = steep ? start_x_ff : start_y_ff;

   logic         geo_steep_ff, geo_len_nz_ff, geo_neg_ff;
   logic [C-1:0] geo_ax_ff, geo_ay_ff, geo_lo_ff, geo_hi_ff;

   always_ff @(posedge clock) begin
      if (div_start) begin
         geo_steep_ff  <= steep;
         geo_len_nz_ff <= amaj != '0;
         geo_neg_ff    <= dx_w[C] ^ dy_w[C];
         geo_ax_ff     <= maj_a;
         geo_ay_ff     <= min_a;
         geo_lo_ff     <= (maj_a < maj_b) ? maj_a : maj_b;
         geo_hi_ff     <= (maj_a < maj_b) ? maj_b : maj_a;
      end
   end

   logic [NB-1:0] div_quot;

   lpc_div #(
      .NUM_BITS (NB),
      .DEN_BITS (C)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({amin, {F{1'b0}}}),
      .den   (amaj),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // slope magnitude never exceeds one for a line of nonzero length
   logic signed [KW-1:0] k_mag, k_in, geo_k_ff;

   assign k_mag = $signed({1'b0, div_quot[F:0]});
   assign k_in  = geo_neg_ff ? -k_mag : k_mag;

   always_ff @(posedge clock) begin
      if (k_load) begin
         geo_k_ff <= k_in;
      end
   end

   // pipeline stall chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, en_out;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en3       = !s3_valid_ff || en_out;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = setup_ready && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid && req_ready;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en_out) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: axis swap, span test, offset along major axis
   logic [C-1:0]      px_m, py_m;
   logic              s1_span_in, s1_span_ff;
   logic signed [C:0] s1_rel_in, s1_rel_ff;
   logic [C-1:0]      s1_py_ff;

   assign px_m       = geo_steep_ff ? req_pixel_y : req_pixel_x;
   assign py_m       = geo_steep_ff ? req_pixel_x : req_pixel_y;
   assign s1_span_in = geo_len_nz_ff && (px_m >= geo_lo_ff) && (px_m < geo_hi_ff);
   assign s1_rel_in  = $signed({1'b0, px_m}) - $signed({1'b0, geo_ax_ff});

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_span_ff <= s1_span_in;
         s1_rel_ff  <= s1_rel_in;
         s1_py_ff   <= py_m;
      end
   end

   // stage 2: slope multiply
   logic signed [PW-1:0] s2_prod_in, s2_prod_ff;
   logic                 s2_span_ff;
   logic [C-1:0]         s2_py_ff;

   assign s2_prod_in = s1_rel_ff * geo_k_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_prod_ff <= s2_prod_in;
         s2_span_ff <= s1_span_ff;
         s2_py_ff   <= s1_py_ff;
      end
   end

   // stage 3: intercept, rounding, neighbor classification
   logic signed [PW-1:0] ideal_h;
   logic signed [YW-1:0] yline;
   logic signed [DW-1:0] diff;
   logic                 s3_on_ff, s3_below_ff, s3_above_ff, s3_span_ff;
   logic [F-1:0]         s3_efx_ff;

   assign ideal_h = $signed(PW'({geo_ay_ff, {F{1'b0}}})) + s2_prod_ff + $signed(HALF_FX);
   assign yline   = ideal_h[PW-1:F];
   assign diff    = $signed({4'b0000, s2_py_ff}) - $signed({yline[YW-1], yline});

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_span_ff  <= s2_span_ff;
         s3_on_ff    <= diff == '0;
         s3_below_ff <= diff == -DIFF_ONE;
         s3_above_ff <= diff == DIFF_ONE;
         s3_efx_ff   <= ideal_h[F-1:0];
      end
   end

   // stage 4: level scaling into the output register
   logic [F:0]   one_minus_e;
   logic [F+8:0] lvl_below_w;
   logic [F+7:0] lvl_above_w;
   logic         we_in, rsp_we_ff;
   logic [7:0]   lvl_in, rsp_lvl_ff;

   assign one_minus_e = (F+1)'(1) << F;
   assign lvl_below_w = {(one_minus_e - {1'b0, s3_efx_ff}), 8'h00}
                        - (F+9)'(one_minus_e - {1'b0, s3_efx_ff});
   assign lvl_above_w = {s3_efx_ff, 8'h00} - (F+8)'(s3_efx_ff);

   always_comb begin
      we_in  = 1'b0;
      lvl_in = '0;
      if (s3_span_ff) begin
         if (s3_on_ff) begin
            we_in  = 1'b1;
            lvl_in = LEVEL_FULL;
         end else if (antialias_ff && s3_below_ff) begin
            we_in  = 1'b1;
            lvl_in = lvl_below_w[F+7:F];
         end else if (antialias_ff && s3_above_ff) begin
            we_in  = 1'b1;
            lvl_in = lvl_above_w[F+7:F];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_we_ff  <= we_in;
         rsp_lvl_ff <= lvl_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_red_level    = rsp_lvl_ff;

   `LPC_ASSERT_IMPL(a_idle_level, clock, reset, rsp_valid && !rsp_write_enable, rsp_red_level == 8'd0)
   `LPC_ASSERT_IMPL(a_no_accept_in_setup, clock, reset, req_valid && req_ready, !div_busy)
   `LPC_ASSERT_IMPL(a_one_class, clock, reset, s3_valid_ff, $onehot0({s3_on_ff, s3_below_ff, s3_above_ff}))
   `LPC_ASSERT_NEXT(a_csr_blocks, clock, reset, csr_valid && csr_ready, !req_ready)

endmodule

[bench/line_pixel_coverage_core_tb.sv]
// Self-checking testbench for line_pixel_coverage_core: directed lines, then random
// lines with near-line pixel streams. Needs only lpc_pkg and the core RTL.
`timescale 1ns / 100ps

module line_pixel_coverage_core_tb import lpc_pkg::*; ();

   localparam int     COORD_BITS    = COORD_BITS_DEF;
   localparam int     FRAC_BITS     = FRAC_BITS_DEF;
   localparam longint ONE           = longint'(1) <<< FRAC_BITS;
   localparam longint HALF          = longint'(1) <<< (FRAC_BITS - 1);
   localparam int     PIXEL_TARGET  = 1450;
   localparam int     STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic                  antialias;
   } line_regs_type;

   typedef struct {
      bit     steep;
      longint ax;
      longint ay;
      longint dx;
      longint lo;
      longint hi;
      longint slope;
   } line_type;

   typedef struct packed {
      logic       write_enable;
      logic [7:0] red_level;
   } coverage_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } pixel_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [COORD_BITS-1:0]     req_pixel_x = '0;
   logic [COORD_BITS-1:0]     req_pixel_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_write_enable;
   logic [7:0]                rsp_red_level;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COORD_BITS-1:0]     csr_wdata = '0;

   line_regs_type line_regs = '0;
   line_type      cur_line;
   coverage_type  pending_coverage[$];
   int            fail_count = 0;
   int            pixels_sent = 0;
   int            lines_loaded = 0;
   int            pixels_written = 0;
   int            partial_levels = 0;
   int            stalled_cycles = 0;

   line_pixel_coverage_core #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_enable(rsp_write_enable),
      .rsp_red_level   (rsp_red_level),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // major axis, slope and intercept origin of the configured line
   function automatic line_type derive_line(input line_regs_type r);
      line_type l;
      longint   bx, by, dx, dy, t;
      l.ax = r.start_x;
      l.ay = r.start_y;
      bx = r.end_x;
      by = r.end_y;
      dx = bx - l.ax;
      dy = by - l.ay;
      l.steep = (dx < 0 ? -dx : dx) < (dy < 0 ? -dy : dy);
      if (l.steep) begin
         t = l.ax; l.ax = l.ay; l.ay = t;
         t = bx; bx = by; by = t;
         t = dx; dx = dy; dy = t;
      end
      l.dx = dx;
      l.lo = l.ax < bx ? l.ax : bx;
      l.hi = l.ax < bx ? bx : l.ax;
      l.slope = (dx != 0) ? (dy * ONE) / dx : 0;
      return l;
   endfunction

   function automatic longint ideal_minor(input longint major);
      return cur_line.ay * ONE + (major - cur_line.ax) * cur_line.slope;
   endfunction

   function automatic coverage_type predict_coverage(input pixel_type p);
      coverage_type res;
      longint       major, minor, ideal, yline, frac;
      res = '0;
      major = cur_line.steep ? p.y : p.x;
      minor = cur_line.steep ? p.x : p.y;
      if (cur_line.dx != 0 && major >= cur_line.lo && major < cur_line.hi) begin
         ideal = ideal_minor(major);
         yline = (ideal + HALF) >>> FRAC_BITS;
         frac = ideal - yline * ONE + HALF;
         if (minor == yline) begin
            res.write_enable = 1'b1;
            res.red_level = LEVEL_FULL;
         end else if (line_regs.antialias) begin
            if (minor == yline - 1) begin
               res.write_enable = 1'b1;
               res.red_level = 8'((longint'(LEVEL_FULL) * (ONE - frac)) >>> FRAC_BITS);
            end else if (minor == yline + 1) begin
               res.write_enable = 1'b1;
               res.red_level = 8'((longint'(LEVEL_FULL) * frac) >>> FRAC_BITS);
            end
         end
      end
      return res;
   endfunction

   // pixel at a given major coordinate, offset from the rounded line along the minor axis
   function automatic pixel_type pixel_on_line(input longint major, input int offset);
      pixel_type p;
      longint    minor;
      minor = ((ideal_minor(major) + HALF) >>> FRAC_BITS) + offset;
      if (cur_line.steep) begin
         p.x = minor[COORD_BITS-1:0];
         p.y = major[COORD_BITS-1:0];
      end else begin
         p.x = major[COORD_BITS-1:0];
         p.y = minor[COORD_BITS-1:0];
      end
      return p;
   endfunction

   task automatic send_pixel(input pixel_type p);
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel_x <= p.x;
      req_pixel_y <= p.y;
      do @(posedge clock); while (!req_ready);
      pending_coverage.push_back(predict_coverage(p));
      pixels_sent++;
   endtask

   task automatic hold_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_for_results();
      hold_sender(0);
      while (pending_coverage.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [COORD_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_START_X:   line_regs.start_x = data;
         CSR_START_Y:   line_regs.start_y = data;
         CSR_END_X:     line_regs.end_x = data;
         CSR_END_Y:     line_regs.end_y = data;
         CSR_ANTIALIAS: line_regs.antialias = data[0];
         default: ;
      endcase
      cur_line = derive_line(line_regs);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_line(input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                            input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                            input logic aa);
      logic [COORD_BITS-1:0] aa_word;
      wait_for_results();
      aa_word = COORD_BITS'($urandom);
      aa_word[0] = aa;
      write_reg(CSR_START_X, sx);
      write_reg(CSR_START_Y, sy);
      write_reg(CSR_END_X, ex);
      write_reg(CSR_END_Y, ey);
      write_reg(CSR_ANTIALIAS, aa_word);
      lines_loaded++;
   endtask

   // registers still at reset: a zero-length line covers nothing
   task automatic test_reset_line();
      send_pixel('{x: '0, y: '0});
      send_pixel('{x: '1, y: '1});
   endtask

   task automatic test_diagonal_extremes();
      load_line('0, '0, '1, '1, 1'b1);
      send_pixel(pixel_on_line(0, 0));
      send_pixel(pixel_on_line(2046, 0));
      send_pixel(pixel_on_line(2047, 0));
      send_pixel(pixel_on_line(5, -1));
      send_pixel(pixel_on_line(5, 1));
      load_line('0, '1, '1, '0, 1'b1);
      send_pixel(pixel_on_line(0, 0));
      send_pixel(pixel_on_line(1, 1));
   endtask

   // steep line with negative dx; pixels get swapped axes
   task automatic test_steep_reversed();
      load_line(11'd300, 11'd10, 11'd290, 11'd900, 1'b1);
      send_pixel(pixel_on_line(10, 0));
      send_pixel(pixel_on_line(899, -1));
      send_pixel(pixel_on_line(450, 1));
      send_pixel(pixel_on_line(900, 0));
   endtask

   task automatic test_flat_and_vertical();
      load_line(11'd50, 11'd100, 11'd10, 11'd100, 1'b0);
      send_pixel(pixel_on_line(10, 0));
      send_pixel(pixel_on_line(49, 0));
      send_pixel(pixel_on_line(9, 0));
      send_pixel(pixel_on_line(20, 1));
      load_line(11'd7, 11'd3, 11'd7, 11'd40, 1'b1);
      send_pixel(pixel_on_line(3, 0));
      send_pixel(pixel_on_line(39, -1));
   endtask

   // slope 1/2: ideal lands exactly on a half, rounds up with zero fraction
   task automatic test_rounding_half();
      load_line(11'd0, 11'd0, 11'd4, 11'd2, 1'b1);
      send_pixel(pixel_on_line(1, 0));
      send_pixel(pixel_on_line(1, -1));
      send_pixel(pixel_on_line(1, 1));
   endtask

   // writes to indexes past the register list must leave the line alone
   task automatic test_unused_index();
      load_line(11'd20, 11'd20, 11'd60, 11'd40, 1'b1);
      for (int i = CSR_ANTIALIAS + 1; i < 2 ** CSR_INDEX_BITS; i++) begin
         write_reg(CSR_INDEX_BITS'(i), COORD_BITS'($urandom));
      end
      send_pixel(pixel_on_line(30, 0));
      send_pixel(pixel_on_line(30, 1));
   endtask

   task automatic test_random_lines();
      int                    shape, pix_left, burst_left, bursts, pick, d;
      logic [COORD_BITS-1:0] sx, sy, ex, ey;
      longint                major;
      pixel_type             p;
      bursts = 0;
      while (pixels_sent < PIXEL_TARGET) begin
         sx = COORD_BITS'($urandom);
         sy = COORD_BITS'($urandom);
         ex = COORD_BITS'($urandom);
         ey = COORD_BITS'($urandom);
         shape = $urandom_range(0, 5);
         case (shape)
            1: begin
               ex = sx + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
               ey = sy + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
            end
            2: begin
               if ($urandom_range(0, 1)) ey = sy;
               else ex = sx;
            end
            3: begin
               d = $urandom_range(0, 300);
               sx = COORD_BITS'($urandom_range(0, 1700));
               sy = COORD_BITS'($urandom_range(300, 1700));
               ex = sx + COORD_BITS'(d);
               ey = $urandom_range(0, 1) ? sy + COORD_BITS'(d) : sy - COORD_BITS'(d);
            end
            4: begin
               ex = sx;
               ey = sy;
            end
            5: begin
               sx = $urandom_range(0, 1) ? '1 : '0;
               sy = $urandom_range(0, 1) ? '1 : '0;
               ex = $urandom_range(0, 1) ? '1 : '0;
               ey = $urandom_range(0, 1) ? '1 : '0;
            end
            default: ;
         endcase
         load_line(sx, sy, ex, ey, $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            write_reg(CSR_INDEX_BITS'($urandom_range(CSR_ANTIALIAS + 1, 2 ** CSR_INDEX_BITS - 1)),
                      COORD_BITS'($urandom));
         end
         pix_left = $urandom_range(15, 70);
         burst_left = $urandom_range(1, 32);
         while (pix_left > 0) begin
            pick = $urandom_range(0, 9);
            if (cur_line.dx == 0 || pick == 0) begin
               p.x = COORD_BITS'($urandom);
               p.y = COORD_BITS'($urandom);
            end else if (pick == 1) begin
               major = $urandom_range(0, 1) ? cur_line.lo - 1 : cur_line.hi;
               p = pixel_on_line(major, $urandom_range(0, 4) - 2);
            end else begin
               major = cur_line.lo + $urandom_range(0, cur_line.hi - cur_line.lo - 1);
               p = pixel_on_line(major, $urandom_range(0, 4) - 2);
            end
            send_pixel(p);
            pix_left--;
            burst_left--;
            if (burst_left == 0 && pix_left > 0) begin
               bursts++;
               if (bursts % 9 == 4) wait_for_results();
               else if ($urandom_range(0, 3) != 0) hold_sender($urandom_range(1, 15));
               burst_left = $urandom_range(1, 32);
            end
         end
      end
   endtask

   initial begin
      int mode, span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         for (int step = 0; step < span; step++) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (step > 25);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      coverage_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_coverage.size() == 0) begin
            $error("result item with no pixel outstanding");
            fail_count++;
         end else begin
            want = pending_coverage.pop_front();
            if (rsp_write_enable !== want.write_enable) begin
               $error("write_enable: expected %0d, actual %0d",
                      want.write_enable, rsp_write_enable);
               fail_count++;
            end
            if (rsp_red_level !== want.red_level) begin
               $error("red_level: expected %0d, actual %0d", want.red_level, rsp_red_level);
               fail_count++;
            end
            if (want.write_enable) pixels_written++;
            if (want.write_enable && want.red_level != LEVEL_FULL) partial_levels++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      cur_line = derive_line(line_regs);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_line();
      test_diagonal_extremes();
      test_steep_reversed();
      test_flat_and_vertical();
      test_rounding_half();
      test_unused_index();
      test_random_lines();
      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Checked %0d pixels across %0d line setups: %0d written, %0d at partial level.",
               pixels_sent, lines_loaded, pixels_written, partial_levels);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
